// ===== design/bdf_glyph_bitmap_extractor_assert.svh =====
// Assertion macros shared by the glyph extractor RTL.
`ifndef BDF_GLYPH_BITMAP_EXTRACTOR_ASSERT_SVH
`define BDF_GLYPH_BITMAP_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BGBE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define BGBE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/bgbe_pkg.sv =====
// Shared types, constants and character helpers of the glyph bitmap extractor.
package bgbe_pkg;

   localparam int LINE_CHARS = 64;
   localparam int ROW_MAX    = LINE_CHARS / 2;
   localparam int ROW_AW     = $clog2(ROW_MAX);
   localparam int ROW_CW     = ROW_AW + 1;
   localparam int COL_W      = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CODE_MAX   = 8;

   localparam logic [COL_W-1:0] COL_SAT    = '1;
   localparam logic [COL_W-1:0] START_LEN  = COL_W'(10);
   localparam logic [COL_W-1:0] BITMAP_LEN = COL_W'(6);
   localparam logic [COL_W-1:0] END_LEN    = COL_W'(7);
   localparam logic [COL_W-1:0] LINE_LIM   = COL_W'(LINE_CHARS);
   localparam logic [7:0]       NEWLINE    = 8'd10;

   localparam logic [CSR_IDX_W-1:0] CSR_CODE_CHARS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_LEN   = 1'b1;

   localparam logic [63:0] CODE_CHARS_RST = 64'd842150194;
   localparam logic [3:0]  CODE_LEN_RST   = 4'd4;

   localparam logic REQ_CHAR = 1'b0;
   localparam logic REQ_END  = 1'b1;

   localparam logic [2:0] KIND_DATA    = 3'd0;
   localparam logic [2:0] KIND_DONE    = 3'd1;
   localparam logic [2:0] KIND_MISSING = 3'd2;
   localparam logic [2:0] KIND_ODD     = 3'd3;
   localparam logic [2:0] KIND_BAD     = 3'd4;

   typedef enum logic [1:0] {
      PH_SEARCH,
      PH_BITMAP,
      PH_DATA,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      RES_NONE,
      RES_ROWS,
      RES_SINGLE
   } line_res_type;

   typedef enum logic [1:0] {
      SEL_ROW,
      SEL_KIND,
      SEL_EOS
   } out_sel_type;

   typedef struct packed {
      logic              take_char;
      logic              line_end;
      logic              eos;
      logic              rd_en;
      logic [ROW_AW-1:0] rd_addr;
      logic              out_load;
      out_sel_type       out_sel;
      logic              out_last;
   } dp_cmd_type;

   typedef struct packed {
      line_res_type      line_res;
      logic [ROW_CW-1:0] row_total;
      logic              out_free;
   } dp_stat_type;

   function automatic logic [7:0] start_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = "S";
         4'd1:    c = "T";
         4'd2:    c = "A";
         4'd3:    c = "R";
         4'd4:    c = "T";
         4'd5:    c = "C";
         4'd6:    c = "H";
         4'd7:    c = "A";
         4'd8:    c = "R";
         default: c = " ";
      endcase
      return c;
   endfunction

   function automatic logic [7:0] bitmap_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = "B";
         3'd1:    c = "I";
         3'd2:    c = "T";
         3'd3:    c = "M";
         3'd4:    c = "A";
         default: c = "P";
      endcase
      return c;
   endfunction

   function automatic logic [7:0] end_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = "E";
         3'd1:    c = "N";
         3'd2:    c = "D";
         3'd3:    c = "C";
         3'd4:    c = "H";
         3'd5:    c = "A";
         default: c = "R";
      endcase
      return c;
   endfunction

   // Bit 4 flags a hex digit, bits 3:0 carry its value.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= "0" && c <= "9") begin
         r = {1'b1, 4'(c - "0")};
      end else if (c >= "a" && c <= "f") begin
         r = {1'b1, 4'(c - "a" + 8'd10)};
      end else if (c >= "A" && c <= "F") begin
         r = {1'b1, 4'(c - "A" + 8'd10)};
      end
      return r;
   endfunction

endpackage

// ===== design/bgbe_datapath.sv =====
// Line parser state, row byte memory, code registers and result register.
module bgbe_datapath import bgbe_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_data,
   input  logic [7:0]           in_ch,
   input  dp_cmd_type           cmd,
   output dp_stat_type          stat,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output logic [2:0]           rsp_kind,
   output logic [7:0]           rsp_byte,
   output logic                 rsp_last
);

   logic [63:0]       code_chars_ff;
   logic [3:0]        code_len_ff;
   phase_type         phase_ff, phase_in, phase_line;
   logic [COL_W-1:0]  column_ff, column_in;
   logic [2:0]        pflag_ff, pflag_in;
   logic [3:0]        high_nib_ff, high_nib_in;
   logic              line_bad_ff, line_bad_in;
   logic [ROW_CW-1:0] row_count_ff, row_count_in;
   logic [7:0]        row_mem [ROW_MAX];
   logic [7:0]        rd_data_ff;
   logic [2:0]        kind_ff;
   logic [2:0]        eos_kind_ff;
   logic [ROW_CW-1:0] count_ff;
   logic              out_valid_ff;
   logic [2:0]        out_kind_ff;
   logic [7:0]        out_byte_ff;
   logic              out_last_ff;

   logic [3:0]       used_len;
   logic [COL_W-1:0] code_end;
   logic             m_start, m_bitmap, m_end, done_after;
   logic [4:0]       hexv;
   logic [2:0]       code_idx;
   logic             tgt_has;
   logic [7:0]       tgt_ch;
   logic             too_long, mem_we;

   assign used_len = (code_len_ff > 4'(CODE_MAX)) ? 4'(CODE_MAX) : code_len_ff;
   assign code_end = START_LEN + COL_W'(used_len);
   assign m_start  = pflag_ff[0] && (column_ff >= code_end);
   assign m_bitmap = pflag_ff[1] && (column_ff >= BITMAP_LEN);
   assign m_end    = pflag_ff[2] && (column_ff >= END_LEN);
   assign done_after = (phase_ff == PH_DONE) || ((phase_ff == PH_DATA) && m_end);

   always_comb begin
      case (phase_ff)
         PH_SEARCH: phase_line = m_start  ? PH_BITMAP : PH_SEARCH;
         PH_BITMAP: phase_line = m_bitmap ? PH_DATA   : PH_BITMAP;
         PH_DATA:   phase_line = m_end    ? PH_DONE   : PH_DATA;
         default:   phase_line = PH_DONE;
      endcase
   end

   always_comb begin
      stat.line_res = RES_NONE;
      if (phase_ff == PH_DATA && !m_end && column_ff != '0) begin
         stat.line_res = (line_bad_ff || column_ff[0]) ? RES_SINGLE : RES_ROWS;
      end
      stat.row_total = count_ff;
      stat.out_free  = !out_valid_ff || rsp_tready;
   end

   // Per-character matching against the three line prefixes.
   assign hexv     = hex_value(in_ch);
   assign code_idx = 3'(column_ff - START_LEN);
   assign too_long = column_ff >= LINE_LIM;
   assign mem_we   = cmd.take_char && !too_long && hexv[4] && column_ff[0];

   always_comb begin
      tgt_has = 1'b0;
      tgt_ch  = 8'd0;
      if (column_ff < START_LEN) begin
         tgt_has = 1'b1;
         tgt_ch  = start_char(column_ff[3:0]);
      end else if (column_ff < code_end) begin
         tgt_has = 1'b1;
         tgt_ch  = code_chars_ff[{code_idx, 3'b000} +: 8];
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      column_in    = column_ff;
      pflag_in     = pflag_ff;
      high_nib_in  = high_nib_ff;
      line_bad_in  = line_bad_ff;
      row_count_in = row_count_ff;
      if (cmd.line_end) begin
         phase_in     = cmd.eos ? PH_SEARCH : phase_line;
         column_in    = '0;
         pflag_in     = 3'b111;
         high_nib_in  = 4'd0;
         line_bad_in  = 1'b0;
         row_count_in = '0;
      end else if (cmd.take_char) begin
         if (tgt_has && tgt_ch != in_ch) begin
            pflag_in[0] = 1'b0;
         end
         if (column_ff < BITMAP_LEN && bitmap_char(column_ff[2:0]) != in_ch) begin
            pflag_in[1] = 1'b0;
         end
         if (column_ff < END_LEN && end_char(column_ff[2:0]) != in_ch) begin
            pflag_in[2] = 1'b0;
         end
         if (too_long || !hexv[4]) begin
            line_bad_in = 1'b1;
         end else if (!column_ff[0]) begin
            high_nib_in = hexv[3:0];
         end else begin
            row_count_in = {1'b0, column_ff[ROW_AW:1]} + ROW_CW'(1);
         end
         column_in = (column_ff < COL_SAT) ? column_ff + COL_W'(1) : COL_SAT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_chars_ff <= CODE_CHARS_RST;
         code_len_ff   <= CODE_LEN_RST;
         phase_ff      <= PH_SEARCH;
         column_ff     <= '0;
         pflag_ff      <= 3'b111;
         high_nib_ff   <= 4'd0;
         line_bad_ff   <= 1'b0;
         row_count_ff  <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_write && csr_index == CSR_CODE_CHARS) begin
            code_chars_ff <= csr_data;
         end
         if (csr_write && csr_index == CSR_CODE_LEN) begin
            code_len_ff <= csr_data[3:0];
         end
         phase_ff     <= phase_in;
         column_ff    <= column_in;
         pflag_ff     <= pflag_in;
         high_nib_ff  <= high_nib_in;
         line_bad_ff  <= line_bad_in;
         row_count_ff <= row_count_in;
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Result details latched when a line closes, and the result register loaded on out_load.
   always_ff @(posedge clock) begin
      if (cmd.line_end) begin
         kind_ff     <= line_bad_ff ? KIND_BAD : KIND_ODD;
         count_ff    <= row_count_ff;
         eos_kind_ff <= done_after ? KIND_DONE : KIND_MISSING;
      end
      if (cmd.out_load) begin
         out_last_ff <= cmd.out_last;
         case (cmd.out_sel)
            SEL_ROW: begin
               out_kind_ff <= KIND_DATA;
               out_byte_ff <= rd_data_ff;
            end
            SEL_KIND: begin
               out_kind_ff <= kind_ff;
               out_byte_ff <= 8'd0;
            end
            default: begin
               out_kind_ff <= eos_kind_ff;
               out_byte_ff <= 8'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_mem[column_ff[ROW_AW:1]] <= {high_nib_ff, hexv[3:0]};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= row_mem[cmd.rd_addr];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_kind   = out_kind_ff;
   assign rsp_byte   = out_byte_ff;
   assign rsp_last   = out_last_ff;

endmodule

// ===== design/bgbe_ctrl.sv =====
// Sequencer: accepts characters and steps through the results of a closed line.
module bgbe_ctrl import bgbe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_type,
   input  logic [7:0]  req_ch,
   output logic        req_tready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_RUN,
      S_READ,
      S_PUT,
      S_SINGLE,
      S_EOS
   } state_type;

   state_type         state_ff, state_in;
   logic [ROW_AW-1:0] idx_ff, idx_in;
   logic              eos_pend_ff, eos_pend_in;
   logic              ready_ff;

   logic accept, is_end, last_row;

   assign accept   = req_tvalid && ready_ff;
   assign is_end   = req_type == REQ_END;
   assign last_row = ({1'b0, idx_ff} + ROW_CW'(1)) == stat.row_total;

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      eos_pend_in = eos_pend_ff;
      cmd         = '0;
      cmd.out_sel = SEL_ROW;
      cmd.rd_addr = idx_ff;
      case (state_ff)
         S_RUN: begin
            if (accept) begin
               if (is_end || req_ch == NEWLINE) begin
                  cmd.line_end = 1'b1;
                  cmd.eos      = is_end;
                  eos_pend_in  = is_end;
                  idx_in       = '0;
                  case (stat.line_res)
                     RES_ROWS:   state_in = S_READ;
                     RES_SINGLE: state_in = S_SINGLE;
                     default:    state_in = is_end ? S_EOS : S_RUN;
                  endcase
               end else begin
                  cmd.take_char = 1'b1;
               end
            end
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_PUT;
         end
         S_PUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_ROW;
               cmd.out_last = last_row && !eos_pend_ff;
               if (last_row) begin
                  state_in = eos_pend_ff ? S_EOS : S_RUN;
               end else begin
                  idx_in   = idx_ff + ROW_AW'(1);
                  state_in = S_READ;
               end
            end
         end
         S_SINGLE: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_KIND;
               cmd.out_last = !eos_pend_ff;
               state_in     = eos_pend_ff ? S_EOS : S_RUN;
            end
         end
         S_EOS: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_EOS;
               cmd.out_last = 1'b1;
               state_in     = S_RUN;
            end
         end
         default: state_in = S_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_RUN;
         idx_ff      <= '0;
         eos_pend_ff <= 1'b0;
         ready_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         eos_pend_ff <= eos_pend_in;
         ready_ff    <= state_in == S_RUN;
      end
   end

   assign req_tready = ready_ff;

endmodule

// ===== design/bdf_glyph_bitmap_extractor.sv =====
// Top level of the glyph bitmap extractor: ports, sequencer and datapath.
//
//   channel  direction  tdata / data        tuser        tlast
//   req_     in         ch[7:0]             req_type     -
//   rsp_     out        data_byte[7:0]      kind[2:0]    last
//   csr_     in         csr_data[63:0]      (csr_index)  -
//
// Characters are accepted back to back; one that closes a line holds the
// input for the line's results. Each row byte is a row memory read, then a
// result register load; a dropped-line or final status is a load alone.
// Reset is synchronous and returns the parse state to the search for the
// glyph code; the code registers return to "2122", four characters.
// A stalled rsp_tready holds the result register and, once results are
// pending, the input side too. csr_ready stays high.
`include "bdf_glyph_bitmap_extractor_assert.svh"

module bdf_glyph_bitmap_extractor import bgbe_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // Character channel.
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] ch
   input  logic                 req_tuser,   // [0] req_type
   // Result channel.
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // [7:0] data_byte
   output logic [2:0]           rsp_tuser,   // [2:0] kind
   output logic                 rsp_tlast,
   // Register write channel.
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        csr_write;

   // Registers are writable outside reset; a write lands on this edge.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   bgbe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_type   (req_tuser),
      .req_ch     (req_tdata),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bgbe_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .in_ch      (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_kind   (rsp_tuser),
      .rsp_byte   (rsp_tdata),
      .rsp_last   (rsp_tlast)
   );

   // Load the result register only when it is empty or being drained.
   `BGBE_ASSERT_SAME(a_load_when_free, clock, reset, cmd.out_load, stat.out_free, "result register overwritten")
   // End of stream always owes a status, so the input must close.
   `BGBE_ASSERT_NEXT(a_eos_blocks_input, clock, reset, req_tvalid && req_tready && req_tuser == REQ_END, !req_tready, "input open after end of stream")
   // A final status closes the results of its transfer.
   `BGBE_ASSERT_SAME(a_status_is_last, clock, reset, rsp_tvalid && (rsp_tuser == KIND_DONE || rsp_tuser == KIND_MISSING), rsp_tlast, "status without last")
   // Only data bytes carry a nonzero byte.
   `BGBE_ASSERT_SAME(a_byte_only_data, clock, reset, rsp_tvalid && rsp_tuser != KIND_DATA, rsp_tdata == 8'd0, "status carries data")

endmodule
